// ===== design/tshd_pkg.sv =====
`timescale 1ns / 1ps

package tshd_pkg;

    localparam int READING_W   = 10;
    localparam int MAX_SENSORS = 6;
    localparam int WORD_W      = 6;
    localparam int CODE_W      = 2;
    localparam int CFG_INDEX_W = 1;

    localparam logic [READING_W-1:0] HIGH_RESET = 10'd800;
    localparam logic [READING_W-1:0] LOW_RESET  = 10'd750;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_HIGH_THRESHOLD = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_LOW_THRESHOLD  = 1'b1;

    typedef enum logic [CODE_W-1:0] {
        CODE_SAME = 2'd0,
        CODE_ROSE = 2'd1,
        CODE_FELL = 2'd2
    } change_code_t;

    // detector state seen by the lanes and the output checks
    typedef struct packed {
        logic [WORD_W-1:0] cur_bits;
        logic [WORD_W-1:0] rep_bits;
        change_code_t      last_code;
    } tshd_state_t;

    // what the merge stage decides for the item in flight
    typedef struct packed {
        logic              emit;
        change_code_t      code;
        logic [WORD_W-1:0] word;
    } tshd_result_t;

endpackage

// ===== design/tshd_lane.sv =====
`timescale 1ns / 1ps

module tshd_lane (
    input  logic [tshd_pkg::READING_W-1:0] lit,
    input  logic [tshd_pkg::READING_W-1:0] unlit,
    input  logic [tshd_pkg::READING_W-1:0] high_thr,
    input  logic [tshd_pkg::READING_W-1:0] low_thr,
    input  logic                           cur_bit,
    input  logic                           rep_bit,
    output logic                           next_bit
);
    import tshd_pkg::*;

    logic [READING_W:0] diff;
    logic               neg;

    // borrow out means the 10-bit wrapped difference is huge: always above high
    assign diff = {1'b0, lit} - {1'b0, unlit};
    assign neg  = diff[READING_W];

    always_comb
    begin
        if (!neg && (diff[READING_W-1:0] < low_thr))
            next_bit = 1'b0;
        else if (neg || (diff[READING_W-1:0] > high_thr))
            next_bit = 1'b1;
        else
            next_bit = cur_bit | rep_bit;
    end

endmodule

// ===== design/tshd_merge.sv =====
`timescale 1ns / 1ps

module tshd_merge (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic [tshd_pkg::WORD_W-1:0] lane_word,
    output tshd_pkg::tshd_state_t       state,
    output tshd_pkg::tshd_result_t      result
);
    import tshd_pkg::*;

    logic [WORD_W-1:0] cur_bits_reg;
    logic [WORD_W-1:0] rep_bits_reg;
    change_code_t      last_code_reg;
    change_code_t      code;

    always_comb
    begin
        if (lane_word > rep_bits_reg)
            code = CODE_ROSE;
        else if (lane_word < rep_bits_reg)
            code = CODE_FELL;
        else
            code = CODE_SAME;
    end

    assign result.emit = (code != last_code_reg);
    assign result.code = code;
    assign result.word = lane_word;

    assign state.cur_bits  = cur_bits_reg;
    assign state.rep_bits  = rep_bits_reg;
    assign state.last_code = last_code_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_bits_reg  <= '0;
            rep_bits_reg  <= '0;
            last_code_reg <= CODE_FELL;
        end
        else if (accept)
        begin
            cur_bits_reg <= lane_word;
            if (result.emit)
            begin
                rep_bits_reg  <= lane_word;
                last_code_reg <= code;
            end
        end
    end

endmodule

// ===== design/tape_sensor_hysteresis_detector.sv =====
`timescale 1ns / 1ps
// Throughput: one item per cycle while the skid entry is empty; the limit is the state loop through the
//   sensor lanes and the word compare in the merge stage.
// Reset (rst_n, async, active low): thresholds 800/750, sensor and reported words zero,
//   last code "fell", output and skid stages empty.
module tape_sensor_hysteresis_detector #(
    parameter int SENSOR_COUNT = 6
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration write port
    input  logic                             cfg_write,
    input  logic [tshd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tshd_pkg::READING_W-1:0]   cfg_data,
    // input channel
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [tshd_pkg::READING_W-1:0]   lit_0,
    input  logic [tshd_pkg::READING_W-1:0]   lit_1,
    input  logic [tshd_pkg::READING_W-1:0]   lit_2,
    input  logic [tshd_pkg::READING_W-1:0]   lit_3,
    input  logic [tshd_pkg::READING_W-1:0]   lit_4,
    input  logic [tshd_pkg::READING_W-1:0]   lit_5,
    input  logic [tshd_pkg::READING_W-1:0]   unlit_0,
    input  logic [tshd_pkg::READING_W-1:0]   unlit_1,
    input  logic [tshd_pkg::READING_W-1:0]   unlit_2,
    input  logic [tshd_pkg::READING_W-1:0]   unlit_3,
    input  logic [tshd_pkg::READING_W-1:0]   unlit_4,
    input  logic [tshd_pkg::READING_W-1:0]   unlit_5,
    // output channel
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [tshd_pkg::CODE_W-1:0]      change_code,
    output logic [tshd_pkg::WORD_W-1:0]      sensor_word
);
    import tshd_pkg::*;

    // ------------------------------------------------------------------
    // Threshold registers
    // ------------------------------------------------------------------
    logic [READING_W-1:0] high_thr_reg;
    logic [READING_W-1:0] low_thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_thr_reg <= HIGH_RESET;
            low_thr_reg  <= LOW_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_HIGH_THRESHOLD: high_thr_reg <= cfg_data;
                REG_LOW_THRESHOLD:  low_thr_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sensor lanes: one hysteresis comparator per active sensor.
    // Lanes at or above SENSOR_COUNT are not built; their bits stay zero.
    // ------------------------------------------------------------------
    logic [READING_W-1:0] lit_arr   [MAX_SENSORS];
    logic [READING_W-1:0] unlit_arr [MAX_SENSORS];
    logic [WORD_W-1:0]    lane_word;
    tshd_state_t          state;
    tshd_result_t         result;
    logic                 in_xfer;

    assign lit_arr[0]   = lit_0;
    assign lit_arr[1]   = lit_1;
    assign lit_arr[2]   = lit_2;
    assign lit_arr[3]   = lit_3;
    assign lit_arr[4]   = lit_4;
    assign lit_arr[5]   = lit_5;
    assign unlit_arr[0] = unlit_0;
    assign unlit_arr[1] = unlit_1;
    assign unlit_arr[2] = unlit_2;
    assign unlit_arr[3] = unlit_3;
    assign unlit_arr[4] = unlit_4;
    assign unlit_arr[5] = unlit_5;

    for (genvar i = 0; i < MAX_SENSORS; i++)
    begin : g_lane
        if (i < SENSOR_COUNT)
        begin : g_active
            tshd_lane u_lane (
                .lit      (lit_arr[i]),
                .unlit    (unlit_arr[i]),
                .high_thr (high_thr_reg),
                .low_thr  (low_thr_reg),
                .cur_bit  (state.cur_bits[i]),
                .rep_bit  (state.rep_bits[i]),
                .next_bit (lane_word[i])
            );
        end
        else
        begin : g_unused
            assign lane_word[i] = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Merge: word compare, change code, state update on each transfer
    // ------------------------------------------------------------------
    assign in_xfer = in_valid && !in_stall;

    tshd_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_xfer),
        .lane_word (lane_word),
        .state     (state),
        .result    (result)
    );

    // ------------------------------------------------------------------
    // Output register plus one skid entry. Input is stalled only while the
    // skid entry is occupied, so a waiting result never blocks the next item.
    // ------------------------------------------------------------------
    logic              out_valid_reg;
    logic              out_valid_next;
    change_code_t      out_code_reg;
    logic [WORD_W-1:0] out_word_reg;
    logic              skid_valid_reg;
    logic              skid_valid_next;
    change_code_t      skid_code_reg;
    logic [WORD_W-1:0] skid_word_reg;
    logic              out_xfer;
    logic              produce;
    logic              load_out;
    logic              load_skid;

    assign out_xfer = out_valid_reg && !out_stall;
    assign produce  = in_xfer && result.emit;
    assign in_stall = skid_valid_reg;

    always_comb
    begin
        load_out        = 1'b0;
        load_skid       = 1'b0;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg)
        begin
            // drain skid into the output register
            if (out_xfer)
                skid_valid_next = 1'b0;
        end
        else if (produce)
        begin
            if (!out_valid_reg || out_xfer)
            begin
                load_out       = 1'b1;
                out_valid_next = 1'b1;
            end
            else
            begin
                load_skid       = 1'b1;
                skid_valid_next = 1'b1;
            end
        end
        else if (out_xfer)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg && out_xfer)
        begin
            out_code_reg <= skid_code_reg;
            out_word_reg <= skid_word_reg;
        end
        else if (load_out)
        begin
            out_code_reg <= result.code;
            out_word_reg <= result.word;
        end
        if (load_skid)
        begin
            skid_code_reg <= result.code;
            skid_word_reg <= result.word;
        end
    end

    assign out_valid   = out_valid_reg;
    assign change_code = out_code_reg;
    assign sensor_word = out_word_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    // skid entry is only ever occupied behind a full output register
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid occupied with empty output register");

    // skid fills only when the output was full and stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && out_stall))
        else $error("skid filled while output could take the result");

    // a reported change records its code as the last code
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && result.emit) |=> (state.last_code == $past(result.code)))
        else $error("last code not updated on reported change");

    // unbuilt lanes never contribute bits
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state.cur_bits >> SENSOR_COUNT) == '0))
        else $error("bit set above active sensor count");

endmodule
